/* hdl/c3zb_pkg.sv */
// Shared types and constants for the 3x3 zero-border convolution block.
package c3zb_pkg;

   // Default line length the line store is sized for
   localparam int MAX_WIDTH_DEF = 1024;

   // Field widths
   localparam int PIX_W   = 8;
   localparam int COEF_W  = 16;
   localparam int ROW_W   = 16;
   localparam int COL_W   = 10;
   localparam int VALUE_W = 28;
   localparam int KROW_W  = 3 * COEF_W;
   localparam int WCFG_W  = 11;
   localparam int HCFG_W  = 16;

   // Stream payload widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = KROW_W;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MIDDLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd4;

   // Configuration reset values
   localparam logic [KROW_W-1:0] KERNEL_TOP_RST    = 48'h0;
   localparam logic [KROW_W-1:0] KERNEL_MIDDLE_RST = 48'h1_0000;
   localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RST = 48'h0;
   localparam logic [WCFG_W-1:0] IMAGE_WIDTH_RST   = 11'd64;
   localparam logic [HCFG_W-1:0] IMAGE_HEIGHT_RST  = 16'd64;

   // Job queue between front and back
   localparam int Q_DEPTH = 8;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // At most one job per pixel: up to three results share row, column and value
   typedef struct packed {
      logic [ROW_W-1:0]          row;    // row of the arriving pixel
      logic [COL_W-1:0]          col;    // column of the arriving pixel
      logic signed [VALUE_W-1:0] value;  // window sum for the centre result
      logic                      has_a;  // centre (row-1, col-1)
      logic                      has_b;  // row end (row-1, col)
      logic                      has_c;  // last-row zero (row, col)
      logic                      eof;    // last-row result is the frame end
   } job_type;

   typedef struct packed {
      logic [Q_AW:0] level;
      logic          empty;
   } queue_status_type;

endpackage

/* hdl/c3zb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c3zb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/c3zb_front.sv */
// Front end: configuration, raster counters, line store, window and sum pipeline.
module c3zb_front import c3zb_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_pixel,
   input  queue_status_type      q_status,
   output logic                  push,
   output job_type               push_job
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int LW = (WW > WCFG_W) ? WW : WCFG_W;
   localparam int PROD_W = COEF_W + PIX_W + 1;
   localparam int RSUM_W = PROD_W + 2;
   localparam int TOT_W  = RSUM_W + 2;
   localparam int OCC_W  = Q_AW + 2;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             has_a;
      logic             has_b;
      logic             has_c;
      logic             eof;
      logic             interior;
   } tag_type;

   // Configuration registers
   logic [KROW_W-1:0] kernel_top_ff, kernel_mid_ff, kernel_bot_ff;
   logic [WCFG_W-1:0] width_cfg_ff;
   logic [HCFG_W-1:0] height_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_top_ff <= KERNEL_TOP_RST;
         kernel_mid_ff <= KERNEL_MIDDLE_RST;
         kernel_bot_ff <= KERNEL_BOTTOM_RST;
         width_cfg_ff  <= IMAGE_WIDTH_RST;
         height_cfg_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KERNEL_TOP:    kernel_top_ff <= csr_wdata;
            CSR_KERNEL_MIDDLE: kernel_mid_ff <= csr_wdata;
            CSR_KERNEL_BOTTOM: kernel_bot_ff <= csr_wdata;
            CSR_IMAGE_WIDTH:   width_cfg_ff  <= csr_wdata[WCFG_W-1:0];
            CSR_IMAGE_HEIGHT:  height_cfg_ff <= csr_wdata[HCFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry: width clamped to 1..MAX_WIDTH, height at least 1
   logic [LW-1:0]     width_ext, width_eff;
   logic [HCFG_W-1:0] height_eff;

   always_comb begin
      width_ext = LW'(width_cfg_ff);
      if (width_ext == '0) begin
         width_eff = LW'(1);
      end else if (width_ext > LW'(MAX_WIDTH)) begin
         width_eff = LW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      height_eff = (height_cfg_ff == '0) ? HCFG_W'(1) : height_cfg_ff;
   end

   // Pipeline valid flags, declared early for the credit check
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   // Accept only when the queue can take every item already in flight
   logic [OCC_W-1:0] occupancy;
   logic             accept;

   assign occupancy  = OCC_W'(q_status.level) + OCC_W'(s1_valid_ff) +
                       OCC_W'(s2_valid_ff) + OCC_W'(s3_valid_ff);
   assign req_tready = occupancy < OCC_W'(Q_DEPTH);
   assign accept     = req_tvalid && req_tready;

   // Raster counters; a position outside the geometry restarts the frame
   logic [CW-1:0]    col_ff, col_in, c_cur;
   logic [ROW_W-1:0] row_ff, row_in, r_cur;
   logic             wrap, col_last, row_last;
   tag_type          tag_cur;

   always_comb begin
      wrap     = (LW'(col_ff) >= width_eff) || (row_ff >= height_eff);
      c_cur    = wrap ? '0 : col_ff;
      r_cur    = wrap ? '0 : row_ff;
      col_last = LW'(c_cur) == (width_eff - LW'(1));
      row_last = r_cur == (height_eff - HCFG_W'(1));
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : r_cur + ROW_W'(1);
      end else begin
         col_in = c_cur + CW'(1);
         row_in = r_cur;
      end
      tag_cur.row      = r_cur;
      tag_cur.col      = COL_W'(c_cur);
      tag_cur.has_a    = (r_cur != '0) && (c_cur != '0);
      tag_cur.has_b    = (r_cur != '0) && col_last;
      tag_cur.has_c    = row_last;
      tag_cur.eof      = row_last && col_last;
      tag_cur.interior = (r_cur >= ROW_W'(2)) && (c_cur >= CW'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1: line store read returns; write back the shifted column.
   // Consecutive items hit the same entry only at width one, where every
   // position is border, so no forwarding is needed.
   tag_type             s1_tag_ff;
   logic [PIX_W-1:0]    s1_pix_ff;
   logic [CW-1:0]       s1_addr_ff;
   logic [2*PIX_W-1:0]  line_rd;
   logic [PIX_W-1:0]    top_pix, mid_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_tag_ff  <= tag_cur;
         s1_pix_ff  <= req_pixel;
         s1_addr_ff <= c_cur;
      end
   end

   // Each entry holds {row r-2, row r-1} for its column
   c3zb_ram #(
      .WIDTH(2 * PIX_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data ({mid_pix, s1_pix_ff}),
      .rd_en   (accept),
      .rd_addr (c_cur),
      .rd_data (line_rd)
   );

   assign top_pix = line_rd[2*PIX_W-1:PIX_W];
   assign mid_pix = line_rd[PIX_W-1:0];

   // Window: columns c-2 and c-1 of the three rows
   logic [PIX_W-1:0] win_ff [6];

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= top_pix;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid_pix;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s1_pix_ff;
      end
   end

   function automatic logic signed [PROD_W-1:0] mul_coef(
      input logic [COEF_W-1:0] coef,
      input logic [PIX_W-1:0]  pix
   );
      logic signed [PROD_W-1:0] prod;
      prod = $signed(coef) * $signed({1'b0, pix});
      return prod;
   endfunction

   // Nine products, registered into stage 2
   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [PROD_W-1:0] s2_prod_ff [9];
   tag_type                  s2_tag_ff;

   always_comb begin
      prod_in[0] = mul_coef(kernel_top_ff[15:0],  win_ff[0]);
      prod_in[1] = mul_coef(kernel_top_ff[31:16], win_ff[1]);
      prod_in[2] = mul_coef(kernel_top_ff[47:32], top_pix);
      prod_in[3] = mul_coef(kernel_mid_ff[15:0],  win_ff[2]);
      prod_in[4] = mul_coef(kernel_mid_ff[31:16], win_ff[3]);
      prod_in[5] = mul_coef(kernel_mid_ff[47:32], mid_pix);
      prod_in[6] = mul_coef(kernel_bot_ff[15:0],  win_ff[4]);
      prod_in[7] = mul_coef(kernel_bot_ff[31:16], win_ff[5]);
      prod_in[8] = mul_coef(kernel_bot_ff[47:32], s1_pix_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         s2_prod_ff <= prod_in;
         s2_tag_ff  <= s1_tag_ff;
      end
   end

   // Stage 3: one sum per kernel row
   logic signed [RSUM_W-1:0] rsum_in [3];
   logic signed [RSUM_W-1:0] s3_rsum_ff [3];
   tag_type                  s3_tag_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rsum_in[k] = RSUM_W'(s2_prod_ff[3*k]) + RSUM_W'(s2_prod_ff[3*k+1]) +
                      RSUM_W'(s2_prod_ff[3*k+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s2_valid_ff) begin
         s3_rsum_ff <= rsum_in;
         s3_tag_ff  <= s2_tag_ff;
      end
   end

   // Final sum, forced to zero on the border, then into the queue
   logic signed [TOT_W-1:0] total;

   assign total = TOT_W'(s3_rsum_ff[0]) + TOT_W'(s3_rsum_ff[1]) +
                  TOT_W'(s3_rsum_ff[2]);

   always_comb begin
      push_job.row   = s3_tag_ff.row;
      push_job.col   = s3_tag_ff.col;
      push_job.value = s3_tag_ff.interior ? total[VALUE_W-1:0] : '0;
      push_job.has_a = s3_tag_ff.has_a;
      push_job.has_b = s3_tag_ff.has_b;
      push_job.has_c = s3_tag_ff.has_c;
      push_job.eof   = s3_tag_ff.eof;
   end

   assign push = s3_valid_ff &&
                 (s3_tag_ff.has_a || s3_tag_ff.has_b || s3_tag_ff.has_c);

endmodule

/* hdl/c3zb_fifo.sv */
// Job queue between front and back end.
module c3zb_fifo import c3zb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type         mem_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_AW:0]   level_ff, level_in;

   // Occupancy follows push and pop; the front never pushes into a full queue
   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + (Q_AW + 1)'(1);
      end else if (pop && !push) begin
         level_in = level_ff - (Q_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_AW'(1);
         end
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = mem_ff[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.empty = level_ff == '0;

endmodule

/* hdl/c3zb_back.sv */
// Back end: expands each job into its results and drives the output register.
module c3zb_back import c3zb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      q_status,
   input  job_type               head_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic [2:0] done_ff, done_in;
   logic [2:0] pending, pick, rest;
   logic       load, take;

   // Results of the head job still to send, in order centre, row end, last row
   always_comb begin
      pending = {head_job.has_c, head_job.has_b, head_job.has_a} & ~done_ff;
      pick[0] = pending[0];
      pick[1] = pending[1] && !pending[0];
      pick[2] = pending[2] && !pending[1] && !pending[0];
      rest    = pending & ~pick;
      load    = !rsp_tvalid || rsp_tready;
      take    = load && !q_status.empty;
      pop     = take && (rest == '0);
      done_in = done_ff;
      if (take) begin
         done_in = (rest == '0) ? '0 : (done_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else begin
         done_ff <= done_in;
      end
   end

   // Output register
   logic                      rsp_valid_ff;
   logic [ROW_W-1:0]          out_row_ff;
   logic [COL_W-1:0]          out_col_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic                      last_ff, eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= take;
      end
      if (take) begin
         out_row_ff <= pick[2] ? head_job.row : head_job.row - ROW_W'(1);
         out_col_ff <= pick[0] ? head_job.col - COL_W'(1) : head_job.col;
         value_ff   <= pick[0] ? head_job.value : '0;
         last_ff    <= rest == '0;
         eof_ff     <= pick[2] && head_job.eof;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, value_ff, out_col_ff, out_row_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = eof_ff;

endmodule

/* hdl/conv3x3_zero_border.sv */
// Top level of the streaming 3x3 convolution with zero border.
// An accepted item passes the stage 1 to 3 registers, the job queue and the output register.
// Throughput: one pixel per cycle while req_tready is high; pixels with two or three results
//   hold the back end longer, absorbed by an 8-job queue that throttles req_tready by credit.
// Reset (synchronous, active high): counters, pipeline, queue and output register clear,
//   configuration returns to its defaults; line store and window contents are not cleared.
module conv3x3_zero_border import c3zb_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // pixel stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] pixel
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] out_row, [25:16] out_col,
                                              // [53:26] value, [55:54] zero
   output logic                  rsp_tlast,   // last_of_run
   output logic                  rsp_tuser    // [0] end_of_frame
);

   queue_status_type q_status;
   job_type          push_job, head_job;
   logic             push, pop;

   c3zb_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_pixel  (req_tdata[PIX_W-1:0]),
      .q_status   (q_status),
      .push       (push),
      .push_job   (push_job)
   );

   c3zb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   c3zb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hdl/c3zb_checker.sv */
// Port-level assertions for the convolution top level, with its bind.
module c3zb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // The frame-end result always closes its run
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of frame without last of run");

   // The frame-end position is a border corner and carries zero
   a_eof_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[53:26] == 28'd0)
      else $error("nonzero value at frame end");

   // No result is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind conv3x3_zero_border c3zb_checker u_c3zb_checker (.*);
